// ===== rtl/multichannel_moving_average_top_defines.svh =====
// Assertion macros used by the top-level RTL.
// Each macro expects clk and arst_n in scope.
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MMA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MMA_ASSERT_IMPL(lbl, ante, cons, msg)
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/mma_pkg.sv =====
`default_nettype none
package mma_pkg;

	localparam int WINDOW_DEF   = 16;
	localparam int CHANNELS_DEF = 4;
	localparam int CH_W         = 2;
	localparam int SAMPLE_W     = 16;
	// quotient bits produced by the divider, one per step
	localparam int QUO_W        = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SUM,
		S_ROUND,
		S_ABS,
		S_DIV,
		S_NEG,
		S_FIN
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
	} alu_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/multichannel_moving_average_top.sv =====
// An item is taken only in the idle state, so a new one waits until the last has finished;
// the time per item is set by the one-read-per-cycle sweep of the channel's filled sample
// RAM entries plus the 16-step shared add/sub divider.
// Out-of-range channel: goes straight to the finish state, average is zero.
// Reset (arst_n low, async): write pointers, fill counts, sequencer and output valid clear.
// Sample RAM is not cleared; only entries already written are ever read.
`default_nettype none
`include "multichannel_moving_average_top_defines.svh"
module multichannel_moving_average_top #(
	parameter int WINDOW   = mma_pkg::WINDOW_DEF,
	parameter int CHANNELS = mma_pkg::CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mma_pkg::CH_W-1:0]           channel,
	input  logic signed [mma_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mma_pkg::SAMPLE_W-1:0] average
);

	import mma_pkg::*;

	// index widths
	localparam int IW   = $clog2(WINDOW);
	localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNTW = $clog2(WINDOW + 1);
	localparam int AW   = CW + IW;
	// sum width: sample plus growth over the window, plus a bit of rounding headroom
	localparam int SW   = IW + SAMPLE_W + 1;
	// divider step counter width
	localparam int DCW  = $clog2(QUO_W);

	state_t state_q, state_d;

	// per-channel ring bookkeeping
	logic [IW-1:0]   wp_q  [CHANNELS];
	logic [CNTW-1:0] cnt_q [CHANNELS];

	// current item
	logic [CW-1:0]       ch_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [CNTW-1:0]     cur_cnt_q;
	logic [CNTW-1:0]     issue_q;
	logic                vld_s1, last_s1;
	logic [SW-1:0]       acc_q;
	logic [SW-1:0]       rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic                neg_q;
	logic [DCW-1:0]      div_cnt_q;

	// output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] average_q;

	// control
	logic          in_xfer, ch_ok, rd_en, wr_en, can_load;
	logic [AW-1:0] raddr, waddr;
	logic [SAMPLE_W-1:0] rdata;
	logic [CW-1:0] ch_idx;

	alu_ctl_t      alu_ctl;
	logic [SW-1:0] alu_a, alu_b, alu_y;
	logic [SW-1:0] shifted, mag;

	assign ch_idx   = CW'(channel);
	assign ch_ok    = (32'(channel) < 32'(CHANNELS));
	assign in_xfer  = in_valid && in_ready;
	assign can_load = !out_valid_q || out_ready;

	assign shifted = {rem_q[SW-2:0], quo_q[QUO_W-1]};
	assign mag     = acc_q[SW-1] ? alu_y : acc_q;

	assign waddr = {ch_q, wp_q[ch_q]};
	assign raddr = {ch_q, issue_q[IW-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = ch_ok ? S_WRITE : S_FIN;
			S_WRITE: state_d = S_SUM;
			S_SUM:   if (last_s1) state_d = S_ROUND;
			S_ROUND: state_d = S_ABS;
			S_ABS:   state_d = S_DIV;
			S_DIV:   if (div_cnt_q == DCW'(QUO_W - 1)) state_d = S_NEG;
			S_NEG:   state_d = S_FIN;
			S_FIN:   if (can_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs and shared-unit operand select
	always_comb begin
		in_ready   = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		alu_ctl.op = ALU_ADD;
		alu_a      = acc_q;
		alu_b      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_WRITE: begin
				wr_en = 1'b1;
			end
			S_SUM: begin
				rd_en = (issue_q < cur_cnt_q);
				alu_b = {{(SW-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata};
			end
			S_ROUND: begin
				alu_b = SW'(cur_cnt_q >> 1);
			end
			S_ABS: begin
				alu_ctl.op = ALU_SUB;
				alu_a      = '0;
				alu_b      = acc_q;
			end
			S_DIV: begin
				alu_ctl.op = ALU_SUB;
				alu_a      = shifted;
				alu_b      = SW'(cur_cnt_q);
			end
			S_NEG: begin
				alu_ctl.op = ALU_SUB;
				alu_a      = '0;
				alu_b      = SW'(quo_q);
			end
			default: begin
			end
		endcase
	end

	mma_alu #(.W(SW)) u_alu (
		.ctl (alu_ctl),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y)
	);

	mma_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** AW)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (sample_q),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			last_s1 <= rd_en && (issue_q == cur_cnt_q - CNTW'(1));
			if (state_q == S_WRITE) begin
				wp_q[ch_q] <= (wp_q[ch_q] == IW'(WINDOW - 1)) ? '0 : wp_q[ch_q] + IW'(1);
				if (cnt_q[ch_q] < CNTW'(WINDOW)) begin
					cnt_q[ch_q] <= cnt_q[ch_q] + CNTW'(1);
				end
			end
			if (state_q == S_FIN && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					ch_q     <= ch_idx;
					sample_q <= sample;
					quo_q    <= '0;
				end
			end
			S_WRITE: begin
				cur_cnt_q <= (cnt_q[ch_q] < CNTW'(WINDOW)) ? cnt_q[ch_q] + CNTW'(1)
					: cnt_q[ch_q];
				issue_q   <= '0;
				acc_q     <= '0;
			end
			S_SUM: begin
				if (rd_en) issue_q <= issue_q + CNTW'(1);
				if (vld_s1) acc_q <= alu_y;
			end
			S_ROUND: begin
				acc_q <= alu_y;
			end
			S_ABS: begin
				// C division truncates toward zero: divide the magnitude, fix sign after
				neg_q     <= acc_q[SW-1];
				rem_q     <= mag >> QUO_W;
				quo_q     <= mag[QUO_W-1:0];
				div_cnt_q <= '0;
			end
			S_DIV: begin
				// restoring step: keep the difference when it stays non-negative
				if (!alu_y[SW-1]) begin
					rem_q <= alu_y;
				end else begin
					rem_q <= shifted;
				end
				quo_q     <= {quo_q[QUO_W-2:0], !alu_y[SW-1]};
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			S_NEG: begin
				if (neg_q) quo_q <= alu_y[QUO_W-1:0];
			end
			S_FIN: begin
				if (can_load) average_q <= quo_q[SAMPLE_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

	`MMA_ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state_q != S_IDLE, "accepted item left block idle")
	`MMA_ASSERT_IMPL(a_cnt_range, state_q == S_SUM, (cur_cnt_q != '0) && (cur_cnt_q <= CNTW'(WINDOW)), "fill count out of range")
	`MMA_ASSERT_IMPL(a_rem_below_div, state_q == S_DIV, rem_q < SW'(cur_cnt_q), "partial remainder not below divisor")
	`MMA_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN, "output valid rose outside finish")

endmodule
`default_nettype wire

// ===== rtl/mma_ram.sv =====
`default_nettype none
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/mma_alu.sv =====
`default_nettype none
module mma_alu #(
	parameter int W = 21
) (
	input  mma_pkg::alu_ctl_t ctl,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      y
);

	import mma_pkg::*;

	always_comb begin
		case (ctl.op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a + b;
		endcase
	end

endmodule
`default_nettype wire
